/* rtl/pfd_pkg.sv */
// shared types, register indexes, microcode table and arithmetic helpers for the pid block
package pfd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_P       = 3'd0;
    localparam logic [2:0] REG_GAIN_I       = 3'd1;
    localparam logic [2:0] REG_GAIN_D       = 3'd2;
    localparam logic [2:0] REG_TARGET       = 3'd3;
    localparam logic [2:0] REG_LIMIT_LOW    = 3'd4;
    localparam logic [2:0] REG_LIMIT_HIGH   = 3'd5;
    localparam logic [2:0] REG_FILTER_ALPHA = 3'd6;
    localparam logic [2:0] REG_ENABLE       = 3'd7;

    // status codes on the result
    localparam logic [1:0] STATUS_OFF      = 2'd0;
    localparam logic [1:0] STATUS_HELD     = 2'd1;
    localparam logic [1:0] STATUS_PRIMED   = 2'd2;
    localparam logic [1:0] STATUS_COMPUTED = 2'd3;

    localparam logic [16:0] ALPHA_MIN = 17'd655;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic signed [31:0] LIMIT_HIGH_RESET = 32'sd16711680;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_KEEP,
        MUL_ALPHA
    } mul_sel_t;

    // datapath action of a step
    typedef enum logic [2:0] {
        OP_DECIDE,
        OP_NONE,
        OP_LOAD_P,
        OP_INTEG,
        OP_RAW,
        OP_FSUM,
        OP_FILT,
        OP_DRIVE
    } op_t;

    // sequencing of a step
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_END_IF_SHORT,
        BR_END
    } br_t;

    typedef struct packed {
        mul_sel_t mul;
        op_t      op;
        br_t      br;
    } ucode_t;

    localparam int UCODE_DEPTH = 8;
    localparam int PC_W        = 3;

    // control store: one word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{mul: MUL_HOLD, op: OP_NONE, br: BR_END};
        case (pc)
            3'd0:    w = '{mul: MUL_HOLD,  op: OP_DECIDE, br: BR_END_IF_SHORT};
            3'd1:    w = '{mul: MUL_P,     op: OP_NONE,   br: BR_NEXT};
            3'd2:    w = '{mul: MUL_I,     op: OP_LOAD_P, br: BR_NEXT};
            3'd3:    w = '{mul: MUL_D,     op: OP_INTEG,  br: BR_NEXT};
            3'd4:    w = '{mul: MUL_KEEP,  op: OP_RAW,    br: BR_NEXT};
            3'd5:    w = '{mul: MUL_ALPHA, op: OP_FSUM,   br: BR_NEXT};
            3'd6:    w = '{mul: MUL_HOLD,  op: OP_FILT,   br: BR_NEXT};
            3'd7:    w = '{mul: MUL_HOLD,  op: OP_DRIVE,  br: BR_END};
            default: w = '{mul: MUL_HOLD,  op: OP_NONE,   br: BR_END};
        endcase
        return w;
    endfunction

    // saturate a 48-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -48'sh0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // low limit wins first, then high limit
    function automatic logic signed [31:0] clamp_lim(input logic signed [49:0] x,
                                                     input logic signed [31:0] lo,
                                                     input logic signed [31:0] hi);
        logic signed [49:0] lo_w;
        logic signed [49:0] hi_w;
        logic signed [31:0] r;
        lo_w = $signed({{18{lo[31]}}, lo});
        hi_w = $signed({{18{hi[31]}}, hi});
        if (x < lo_w)
            r = lo;
        else if (x > hi_w)
            r = hi;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

/* rtl/pid_filtered_derivative_top.sv */
// pid controller with filtered derivative on measurement, run by a microcoded sequencer
// a disabled, held or priming item ends at its decide step after the input transfer; a computed item
//   runs all 8 control words, one step each, sharing one 32x32 multiplier
// a new item is taken only once the last one has ended; an ending step also waits on output stall
// reset: rst_n low clears gains, target and enable to 0, limits to 0 and 255.0, alpha to 1.0,
//   and the controller state to its cleared value with the first-sample flag set
module pid_filtered_derivative_top #(
    parameter int SAMPLE_PERIOD_MS = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measurement,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive,
    output logic [1:0]         status
);

    localparam logic [31:0] PERIOD = 32'(SAMPLE_PERIOD_MS);

    // configuration
    logic [30:0]        gain_p_reg;
    logic [30:0]        gain_i_reg;
    logic [30:0]        gain_d_reg;
    logic signed [31:0] target_reg;
    logic signed [31:0] limit_low_reg;
    logic signed [31:0] limit_high_reg;
    logic [16:0]        alpha_cfg_reg;
    logic               enable_reg;

    // controller state
    logic signed [31:0] integral_reg;
    logic signed [31:0] last_meas_reg;
    logic signed [31:0] filt_reg;
    logic signed [31:0] held_reg;
    logic [31:0]        last_time_reg;
    logic               armed_reg;
    logic               first_reg;

    // sequencer and datapath
    logic                     busy_reg;
    logic [pfd_pkg::PC_W-1:0] pc_reg;
    logic signed [31:0]       meas_reg;
    logic [31:0]              now_reg;
    logic signed [31:0]       err_reg;
    logic signed [31:0]       dm_reg;
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       prod_next;
    logic signed [47:0]       p_reg;
    logic signed [31:0]       raw_reg;
    logic signed [63:0]       fsum_reg;

    logic                     out_valid_reg;
    logic signed [31:0]       drive_reg;
    logic [1:0]               status_reg;

    pfd_pkg::ucode_t    uw;
    logic [16:0]        alpha;
    logic [16:0]        alpha_keep;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    logic [31:0]        time_eff;
    logic [31:0]        elapsed;
    logic               not_due;
    logic               short_item;
    logic [1:0]         decide_status;
    logic               ends;
    logic               out_free;
    logic               advance;

    logic signed [32:0] err_wide;
    logic signed [32:0] dm_wide;
    logic signed [48:0] integ_sum;
    logic signed [31:0] integ_new;
    logic signed [63:0] prod_neg;
    logic signed [63:0] fsum_total;
    logic signed [49:0] drive_sum;
    logic signed [31:0] drive_new;

    assign uw = pfd_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        if (alpha_cfg_reg < pfd_pkg::ALPHA_MIN)
            alpha = pfd_pkg::ALPHA_MIN;
        else if (alpha_cfg_reg > pfd_pkg::ALPHA_ONE)
            alpha = pfd_pkg::ALPHA_ONE;
        else
            alpha = alpha_cfg_reg;
    end
    assign alpha_keep = pfd_pkg::ALPHA_ONE - alpha;

    // shared multiplier, operands chosen by the control word
    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        case (uw.mul)
            pfd_pkg::MUL_P:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = err_reg;
            end
            pfd_pkg::MUL_I:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = err_reg;
            end
            pfd_pkg::MUL_D:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = dm_reg;
            end
            pfd_pkg::MUL_KEEP:
            begin
                mul_a = $signed({15'd0, alpha_keep});
                mul_b = filt_reg;
            end
            pfd_pkg::MUL_ALPHA:
            begin
                mul_a = $signed({15'd0, alpha});
                mul_b = raw_reg;
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    always_comb
    begin
        if (uw.mul == pfd_pkg::MUL_HOLD)
            prod_next = prod_reg;
        else
            prod_next = mul_a * mul_b;
    end

    // sample timing decision for the item in hand
    assign time_eff   = armed_reg ? last_time_reg : now_reg;
    assign elapsed    = now_reg - time_eff;
    assign not_due    = elapsed < PERIOD;
    assign short_item = !enable_reg || not_due || first_reg;

    always_comb
    begin
        if (!enable_reg)
            decide_status = pfd_pkg::STATUS_OFF;
        else if (not_due)
            decide_status = pfd_pkg::STATUS_HELD;
        else if (first_reg)
            decide_status = pfd_pkg::STATUS_PRIMED;
        else
            decide_status = pfd_pkg::STATUS_COMPUTED;
    end

    always_comb
    begin
        case (uw.br)
            pfd_pkg::BR_END_IF_SHORT: ends = short_item;
            pfd_pkg::BR_END:          ends = 1'b1;
            default:                  ends = 1'b0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    // an ending step waits until the output register can take the result
    assign advance  = busy_reg && (!ends || out_free);

    // datapath arithmetic
    assign err_wide   = $signed({target_reg[31], target_reg}) - $signed({meas_reg[31], meas_reg});
    assign dm_wide    = $signed({meas_reg[31], meas_reg})
                      - $signed({last_meas_reg[31], last_meas_reg});
    assign integ_sum  = $signed({{17{integral_reg[31]}}, integral_reg})
                      + $signed({prod_reg[63], prod_reg[63:16]});
    assign integ_new  = pfd_pkg::clamp_lim($signed({integ_sum[48], integ_sum}),
                                           limit_low_reg, limit_high_reg);
    assign prod_neg   = -prod_reg;
    assign fsum_total = fsum_reg + prod_reg;
    assign drive_sum  = $signed({{2{p_reg[47]}}, p_reg})
                      + $signed({{18{integral_reg[31]}}, integral_reg})
                      + $signed({{18{filt_reg[31]}}, filt_reg});
    assign drive_new  = pfd_pkg::clamp_lim(drive_sum, limit_low_reg, limit_high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            target_reg     <= '0;
            limit_low_reg  <= '0;
            limit_high_reg <= pfd_pkg::LIMIT_HIGH_RESET;
            alpha_cfg_reg  <= pfd_pkg::ALPHA_ONE;
            enable_reg     <= 1'b0;
            integral_reg   <= '0;
            last_meas_reg  <= '0;
            filt_reg       <= '0;
            held_reg       <= '0;
            last_time_reg  <= '0;
            armed_reg      <= 1'b0;
            first_reg      <= 1'b1;
            busy_reg       <= 1'b0;
            pc_reg         <= '0;
            meas_reg       <= '0;
            now_reg        <= '0;
            err_reg        <= '0;
            dm_reg         <= '0;
            prod_reg       <= '0;
            p_reg          <= '0;
            raw_reg        <= '0;
            fsum_reg       <= '0;
            out_valid_reg  <= 1'b0;
            drive_reg      <= '0;
            status_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !(advance && ends))
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_idx)
                    pfd_pkg::REG_GAIN_P:       gain_p_reg     <= cfg_data[30:0];
                    pfd_pkg::REG_GAIN_I:       gain_i_reg     <= cfg_data[30:0];
                    pfd_pkg::REG_GAIN_D:       gain_d_reg     <= cfg_data[30:0];
                    pfd_pkg::REG_TARGET:       target_reg     <= cfg_data;
                    pfd_pkg::REG_LIMIT_LOW:    limit_low_reg  <= cfg_data;
                    pfd_pkg::REG_LIMIT_HIGH:   limit_high_reg <= cfg_data;
                    pfd_pkg::REG_FILTER_ALPHA: alpha_cfg_reg  <= cfg_data[16:0];
                    pfd_pkg::REG_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                        if (cfg_data[0] && !enable_reg)
                        begin
                            // bumpless start
                            integral_reg  <= '0;
                            last_meas_reg <= '0;
                            filt_reg      <= '0;
                            held_reg      <= '0;
                            last_time_reg <= '0;
                            armed_reg     <= 1'b0;
                            first_reg     <= 1'b1;
                        end
                        else if (!cfg_data[0])
                            held_reg <= '0;
                    end
                    default: ;
                endcase
            end

            if (in_valid && !busy_reg)
            begin
                meas_reg <= measurement;
                now_reg  <= now_ms;
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end

            if (advance)
            begin
                prod_reg <= prod_next;
                case (uw.op)
                    pfd_pkg::OP_DECIDE:
                    begin
                        if (!enable_reg)
                            held_reg <= '0;
                        else
                        begin
                            armed_reg <= 1'b1;
                            if (!not_due)
                            begin
                                last_meas_reg <= meas_reg;
                                last_time_reg <= now_reg;
                                first_reg     <= 1'b0;
                                err_reg       <= pfd_pkg::sat32(48'(err_wide));
                                dm_reg        <= pfd_pkg::sat32(48'(dm_wide));
                            end
                            else
                                last_time_reg <= time_eff;
                        end
                        // computed items report from the drive step
                        if (short_item)
                        begin
                            drive_reg  <= enable_reg ? held_reg : 32'sd0;
                            status_reg <= decide_status;
                        end
                    end
                    pfd_pkg::OP_LOAD_P: p_reg        <= prod_reg[63:16];
                    pfd_pkg::OP_INTEG:  integral_reg <= integ_new;
                    pfd_pkg::OP_RAW:    raw_reg      <= pfd_pkg::sat32(prod_neg[63:16]);
                    pfd_pkg::OP_FSUM:   fsum_reg     <= prod_reg;
                    pfd_pkg::OP_FILT:   filt_reg     <= fsum_total[47:16];
                    pfd_pkg::OP_DRIVE:
                    begin
                        held_reg   <= drive_new;
                        drive_reg  <= drive_new;
                        status_reg <= pfd_pkg::STATUS_COMPUTED;
                    end
                    default: ;
                endcase

                if (ends)
                begin
                    busy_reg      <= 1'b0;
                    out_valid_reg <= 1'b1;
                    pc_reg        <= '0;
                end
                else
                    pc_reg <= pc_reg + 1'b1;
            end
        end
    end

    assign in_ready  = !busy_reg;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign status    = status_reg;

endmodule

/* rtl/pfd_checker.sv */
// port-level checks for the pid block, bound to the top level
module pfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] drive,
    input logic [1:0]         status
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(status))
        else $error("result changed while stalled");

    // a disabled controller drives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pfd_pkg::STATUS_OFF |-> drive == 32'sd0)
        else $error("disabled result not zero");

    // one item at a time: an input transfer closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after transfer");

    // a new result only comes out of an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item in flight");

endmodule

bind pid_filtered_derivative_top pfd_checker u_pfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .status    (status)
);
